// ===== rtl/dtcp_pkg.sv =====
// Package for the DMA transfer chunk planner.
// Transaction types, command and event codes, sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package dtcp_pkg;

  localparam int MAX_DIVISOR    = 2048;
  localparam int DIV_W          = $clog2(MAX_DIVISOR + 1);
  localparam int REPS_W         = 11;
  localparam int ALIGN_SH       = 6;
  localparam int UNITS_MAX      = 65528 / 64;
  localparam int UNITS_W        = $clog2(UNITS_MAX + 1);
  localparam int LEN_UNITS_W    = 32 - ALIGN_SH;
  localparam int REM_W          = $clog2(MAX_DIVISOR * UNITS_MAX + 1) + 1;

  localparam logic [31:0] SINGLE_MAX   = 32'd65535;
  localparam logic [31:0] SW_CHUNK_MAX = 32'd65280;
  localparam logic [31:0] PERIPH_LOW   = 32'h4000_0000;
  localparam logic [31:0] PERIPH_HIGH  = 32'h5FFF_FFFF;

  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_COMPLETE = 2'd1;
  localparam logic [1:0] CMD_ERROR    = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_BLOCK    = 2'd1;
  localparam logic [1:0] EV_COMPLETE = 2'd2;
  localparam logic [1:0] EV_ERROR    = 2'd3;

  localparam logic [1:0] CFG_INC_SOURCE      = 2'd0;
  localparam logic [1:0] CFG_INC_DESTINATION = 2'd1;
  localparam logic [1:0] CFG_FORCE_SW_CHUNKS = 2'd2;
  localparam logic [1:0] CFG_REPEAT_CAPABLE  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] byte_length;
    logic [15:0] hw_block_left;
    logic [10:0] hw_repeats_left;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  event_res;
    logic [31:0] block_source;
    logic [31:0] block_dest;
    logic [15:0] block_bytes;
    logic [10:0] repeat_count;
    logic        source_port;
    logic        dest_port;
    logic [31:0] bytes_remaining;
  } res_t;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [UNITS_W-1:0] units;
    logic [REPS_W-1:0]  reps;
  } srch_res_t;

endpackage

// ===== rtl/dtcp_search.sv =====
// Divisor search for repeated-block splitting: shift-subtract division per candidate divisor.
// Depends on dtcp_pkg.
`timescale 1ns / 1ps

module dtcp_search import dtcp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [LEN_UNITS_W-1:0] len_units,
  output srch_res_t              res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;

  logic [1:0]         state, state_next;
  logic [DIV_W-1:0]   div, div_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic [REM_W-1:0]   dsh, dsh_next;
  logic [3:0]         step, step_next;
  logic [UNITS_W-1:0] quo, quo_next;
  logic               done, done_next;
  logic               found, found_next;
  logic [LEN_UNITS_W-1:0] bound;
  logic [REM_W-1:0]   diff;
  logic               ge;
  logic               last_div;

  assign bound = LEN_UNITS_W'({div, 10'd0}) - LEN_UNITS_W'(div);
  assign diff  = rem - dsh;
  assign ge    = rem >= dsh;
  assign last_div = div == DIV_W'(MAX_DIVISOR);

  always_comb begin
    state_next = state;
    div_next   = div;
    rem_next   = rem;
    dsh_next   = dsh;
    step_next  = step;
    quo_next   = quo;
    done_next  = done;
    found_next = found;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          div_next   = DIV_W'(1);
          done_next  = 1'b0;
          found_next = 1'b0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (len_units <= bound) begin
          rem_next   = REM_W'(len_units);
          dsh_next   = REM_W'({div, 9'd0});
          step_next  = 4'd9;
          quo_next   = '0;
          state_next = S_DIV;
        end else if (last_div) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          div_next = div + DIV_W'(1);
        end
      end
      S_DIV: begin
        if (ge) begin
          rem_next = diff;
          quo_next[step] = 1'b1;
        end
        dsh_next  = dsh >> 1;
        step_next = step - 4'd1;
        if (step == 4'd0) begin
          if ((ge ? diff : rem) == '0) begin
            done_next  = 1'b1;
            found_next = 1'b1;
            state_next = S_IDLE;
          end else if (last_div) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            div_next   = div + DIV_W'(1);
            state_next = S_CHECK;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      found <= found_next;
    end
    div  <= div_next;
    rem  <= rem_next;
    dsh  <= dsh_next;
    step <= step_next;
    quo  <= quo_next;
  end

  assign res.done  = done;
  assign res.found = found;
  assign res.units = quo;
  assign res.reps  = REPS_W'(div - DIV_W'(1));

`ifndef NO_ASSERTIONS
  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && found |-> quo != '0) else $error("search found zero block");
`endif

endmodule

// ===== rtl/dma_transfer_chunk_planner.sv =====
// DMA transfer chunk planner top level: command sequencer and result register.
// Depends on dtcp_pkg and dtcp_search.
// Block complete, error and zero/short start are answered from the execute state; query adds a summing state.
// Long start on a repeat-capable channel runs the divisor search: per candidate divisor,
// a bound check and, if it passes, 10 subtract steps; up to 2048 candidates.
// Throughput: one transaction at a time; a new command is taken once the previous result is queued.
// Reset (rst, synchronous): configuration to defaults, addresses and counts to zero.
`timescale 1ns / 1ps

module dma_transfer_chunk_planner import dtcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_QSUM   = 2'd3;

  logic [1:0]  state, state_next;
  cmd_t        req;
  logic        inc_source, inc_destination, force_sw_chunks, repeat_capable;
  logic [31:0] current_source, current_source_next;
  logic [31:0] current_dest, current_dest_next;
  logic [31:0] bytes_left_sw, bytes_left_sw_next;
  logic [31:0] block_size_now, block_size_now_next;
  logic [31:0] prod;
  logic        res_valid_next;
  res_t        res_next;
  logic        out_free;
  logic        emit;
  logic        srch_start;
  srch_res_t   srch;
  logic [31:0] chunk_src, chunk, chunk_left;

  function automatic logic port_of(input logic [31:0] a);
    return (a >= PERIPH_LOW) && (a <= PERIPH_HIGH);
  endfunction

  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = state != S_IDLE;

  assign chunk_src  = (req.command == CMD_START) ? req.byte_length : bytes_left_sw;
  assign chunk      = (chunk_src > SW_CHUNK_MAX) ? SW_CHUNK_MAX : chunk_src;
  assign chunk_left = chunk_src - chunk;

  dtcp_search u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (srch_start),
    .len_units (req.byte_length[31:ALIGN_SH]),
    .res       (srch)
  );

  always_comb begin
    state_next          = state;
    current_source_next = current_source;
    current_dest_next   = current_dest;
    bytes_left_sw_next  = bytes_left_sw;
    block_size_now_next = block_size_now;
    srch_start          = 1'b0;
    emit                = 1'b0;
    res_next            = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          unique case (req.command)
            CMD_START: begin
              emit = 1'b1;
              if (req.byte_length == '0) begin
                res_next.status = 1'b1;
              end else begin
                current_source_next = req.source_address;
                current_dest_next   = req.dest_address;
                bytes_left_sw_next  = req.byte_length;
                block_size_now_next = req.byte_length;
                if (req.byte_length <= SINGLE_MAX) begin
                  bytes_left_sw_next = '0;
                  res_next.event_res = EV_BLOCK;
                end else if (repeat_capable && !force_sw_chunks) begin
                  if (req.byte_length[ALIGN_SH-1:0] != '0) begin
                    res_next.status = 1'b1;
                  end else begin
                    emit       = 1'b0;
                    srch_start = 1'b1;
                    state_next = S_SEARCH;
                  end
                end else begin
                  block_size_now_next = chunk;
                  bytes_left_sw_next  = chunk_left;
                  res_next.event_res  = EV_BLOCK;
                end
              end
            end
            CMD_COMPLETE: begin
              emit = 1'b1;
              if (bytes_left_sw != '0) begin
                if (inc_source) current_source_next = current_source + block_size_now;
                if (inc_destination) current_dest_next = current_dest + block_size_now;
                block_size_now_next = chunk;
                bytes_left_sw_next  = chunk_left;
                res_next.event_res  = EV_BLOCK;
              end else begin
                res_next.event_res = EV_COMPLETE;
              end
            end
            CMD_ERROR: begin
              emit = 1'b1;
              res_next.event_res = EV_ERROR;
            end
            CMD_QUERY: begin
              state_next = S_QSUM;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (srch.done && out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (srch.found) begin
            block_size_now_next = 32'({srch.units, {ALIGN_SH{1'b0}}});
            bytes_left_sw_next  = '0;
            res_next.event_res  = EV_BLOCK;
            res_next.repeat_count = srch.reps;
          end else begin
            res_next.status = 1'b1;
          end
        end
      end
      S_QSUM: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
          res_next.bytes_remaining = bytes_left_sw + 32'(req.hw_block_left) + prod;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (res_next.event_res == EV_BLOCK) begin
      res_next.block_source = current_source_next;
      res_next.block_dest   = current_dest_next;
      res_next.block_bytes  = block_size_now_next[15:0];
      res_next.source_port  = port_of(current_source_next);
      res_next.dest_port    = port_of(current_dest_next);
    end
  end

  assign res_valid_next = emit ? 1'b1 : (res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      res_valid       <= 1'b0;
      inc_source      <= 1'b1;
      inc_destination <= 1'b1;
      force_sw_chunks <= 1'b0;
      repeat_capable  <= 1'b0;
      current_source  <= '0;
      current_dest    <= '0;
      bytes_left_sw   <= '0;
      block_size_now  <= '0;
    end else begin
      state          <= state_next;
      res_valid      <= res_valid_next;
      current_source <= current_source_next;
      current_dest   <= current_dest_next;
      bytes_left_sw  <= bytes_left_sw_next;
      block_size_now <= block_size_now_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INC_SOURCE:      inc_source      <= cfg_data;
          CFG_INC_DESTINATION: inc_destination <= cfg_data;
          CFG_FORCE_SW_CHUNKS: force_sw_chunks <= cfg_data;
          CFG_REPEAT_CAPABLE:  repeat_capable  <= cfg_data;
          default: ;
        endcase
      end
    end
    if (state == S_IDLE && cmd_valid) req <= cmd;
    prod <= 32'(block_size_now * 32'(req.hw_repeats_left));
    if (emit) res <= res_next;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> state == S_EXEC) else $error("accepted command lost");
  a_block_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == EV_BLOCK |-> res.block_bytes != '0)
    else $error("empty block programmed");
  a_fail_no_event: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status |-> res.event_res == EV_NONE) else $error("failed start with event");
`endif

endmodule
